[rtl/core/rpr_pkg.sv]
// Shared constants, register map and controller/datapath command types of the resampler.
package rpr_pkg;

	// Register and field widths
	localparam int UP_W         = 6;
	localparam int DOWN_W       = 7;
	localparam int TAPS_W       = 13;
	localparam int CI_W         = 12;
	localparam int CV_W         = 18;
	localparam int SMP_W        = 16;
	localparam int PROD_W       = CV_W + SMP_W;
	localparam int FRAC_W       = 15;
	localparam int PHASE_W      = 7;
	localparam int PHASE_WORK_W = 8;

	// APB register map
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;
	localparam logic [1:0] REG_UP   = 2'd0;
	localparam logic [1:0] REG_DOWN = 2'd1;
	localparam logic [1:0] REG_TAPS = 2'd2;

	localparam logic [UP_W-1:0]   UP_RST   = UP_W'(1);
	localparam logic [DOWN_W-1:0] DOWN_RST = DOWN_W'(1);
	localparam logic [TAPS_W-1:0] TAPS_RST = TAPS_W'(1);

	// Input word opcodes
	localparam logic OP_COEF   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic coef_wr;
		logic hist_push;
		logic out_start;
		logic mac_issue;
		logic out_load;
		logic out_last;
		logic phase_adv;
		logic phase_end;
	} rpr_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic phase_lt_u;
		logic next_lt_u;
		logic tap_more;
		logic pipe_busy;
		logic out_free;
	} rpr_sts_t;

endpackage

[rtl/core/rpr_if.sv]
// Valid/ready stream interfaces for input words and result words.
interface rpr_in_if import rpr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    opcode;
	logic [CI_W-1:0]         coef_index;
	logic signed [CV_W-1:0]  coef_value;
	logic signed [SMP_W-1:0] sample;

	modport source (output valid, opcode, coef_index, coef_value, sample, input ready);
	modport sink   (input valid, opcode, coef_index, coef_value, sample, output ready);
endinterface

interface rpr_out_if import rpr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] out_sample;
	logic                    last;

	modport source (output valid, out_sample, last, input ready);
	modport sink   (input valid, out_sample, last, output ready);
endinterface

[rtl/core/rpr_regs.sv]
// APB configuration registers: up factor, down factor and tap count.
module rpr_regs import rpr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [UP_W-1:0]   up_factor,
	output logic [DOWN_W-1:0] down_factor,
	output logic [TAPS_W-1:0] tap_count
);

	logic              wr_en;
	logic [1:0]        reg_idx;
	logic [UP_W-1:0]   up_q;
	logic [DOWN_W-1:0] down_q;
	logic [TAPS_W-1:0] taps_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q   <= UP_RST;
			down_q <= DOWN_RST;
			taps_q <= TAPS_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_UP:   up_q   <= pwdata[UP_W-1:0];
				REG_DOWN: down_q <= pwdata[DOWN_W-1:0];
				REG_TAPS: taps_q <= pwdata[TAPS_W-1:0];
				default:  ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			REG_UP:   prdata = APB_DW'(up_q);
			REG_DOWN: prdata = APB_DW'(down_q);
			REG_TAPS: prdata = APB_DW'(taps_q);
			default:  prdata = '0;
		endcase
	end

	assign up_factor   = up_q;
	assign down_factor = down_q;
	assign tap_count   = taps_q;

endmodule

[rtl/core/rpr_ctrl.sv]
// Sequencer: takes input words, walks the outputs due and the MAC loop of each.
module rpr_ctrl import rpr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_opcode,
	output logic     in_ready,
	input  rpr_sts_t sts,
	output rpr_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MAC,
		S_DRAIN,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_acc;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid & in_ready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.coef_wr   = in_acc && (in_opcode == OP_COEF);
				cmd.hist_push = in_acc && (in_opcode == OP_SAMPLE);
				if (cmd.hist_push)
					state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.phase_lt_u) begin
					cmd.out_start = 1'b1;
					state_d       = S_MAC;
				end else begin
					cmd.phase_end = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_MAC: begin
				if (sts.tap_more)
					cmd.mac_issue = 1'b1;
				else
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!sts.pipe_busy)
					state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_last  = !sts.next_lt_u;
					cmd.phase_adv = 1'b1;
					state_d       = S_CHECK;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// A result only goes into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over a waiting word");

	// A tap is only fetched while taps remain
	a_issue_more: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mac_issue |-> sts.tap_more)
		else $error("tap fetched past end of branch");

	// A sample push always leads to the output check
	a_push_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hist_push |=> !in_ready)
		else $error("input taken before sample handled");

endmodule

[rtl/core/rpr_datapath.sv]
// Datapath: tap and history memories, phase tracking, MAC pipeline, rounding and output register.
module rpr_datapath import rpr_pkg::*; #(
	parameter int MAX_COEFS     = 4096,
	parameter int MAX_UP        = 32,
	parameter int MAX_DOWN      = 64,
	parameter int HISTORY_DEPTH = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rpr_cmd_t                cmd,
	output rpr_sts_t                sts,
	input  logic [UP_W-1:0]         up_factor,
	input  logic [DOWN_W-1:0]       down_factor,
	input  logic [TAPS_W-1:0]       tap_count,
	input  logic [CI_W-1:0]         coef_index,
	input  logic signed [CV_W-1:0]  coef_value,
	input  logic signed [SMP_W-1:0] sample,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic signed [SMP_W-1:0] out_sample,
	output logic                    out_last
);

	localparam int CA_W  = $clog2(MAX_COEFS);
	localparam int HA_W  = $clog2(HISTORY_DEPTH);
	localparam int FL_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int U_W   = $clog2(MAX_UP + 1);
	localparam int D_W   = $clog2(MAX_DOWN + 1);
	localparam int TP_W  = $clog2(MAX_COEFS + 1);
	localparam int K_W   = $clog2(MAX_COEFS + MAX_UP);
	localparam int IX_W  = CI_W + CA_W;
	localparam int ACC_W = PROD_W + HA_W;
	localparam int Q_W   = ACC_W + 1 - FRAC_W;
	localparam int PW    = PHASE_WORK_W;
	localparam int ROUND_HALF = 1 << (FRAC_W - 1);

	localparam logic signed [SMP_W-1:0] SAT_MAX = {1'b0, {(SMP_W-1){1'b1}}};
	localparam logic signed [SMP_W-1:0] SAT_MIN = {1'b1, {(SMP_W-1){1'b0}}};

	// Memories
	logic signed [CV_W-1:0]  coef_mem [MAX_COEFS];
	logic signed [SMP_W-1:0] hist_mem [HISTORY_DEPTH];

	// Effective factors after clamping
	logic [U_W-1:0]  u_eff;
	logic [D_W-1:0]  d_eff;
	logic [TP_W-1:0] taps_eff;

	// History and phase state
	logic [HA_W-1:0] head_q;
	logic [HA_W-1:0] head_nxt;
	logic [FL_W-1:0] fill_q;
	logic [PW-1:0]   phase_q;
	logic [PW-1:0]   phase_diff;
	logic [PW:0]     phase_sum;

	// Tap walk
	logic [K_W-1:0]  k_q;
	logic [FL_W-1:0] j_q;
	logic [HA_W-1:0] rptr_q;

	// MAC pipeline
	logic                    v_s1;
	logic                    v_s2;
	logic signed [CV_W-1:0]  coef_rd_s1;
	logic signed [SMP_W-1:0] hist_rd_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;

	// Rounding
	logic signed [ACC_W:0]   rnd_v;
	logic [Q_W-1:0]          rnd_q;
	logic [Q_W-SMP_W:0]      rnd_top;
	logic signed [SMP_W-1:0] rnd_res;

	// Output register
	logic                    out_valid_q;
	logic signed [SMP_W-1:0] out_sample_q;
	logic                    out_last_q;

	logic [IX_W-1:0] idx_ext;
	logic            idx_ok;

	// Clamp configuration
	always_comb begin
		if (up_factor == '0)
			u_eff = U_W'(1);
		else if (32'(up_factor) > 32'(MAX_UP))
			u_eff = U_W'(MAX_UP);
		else
			u_eff = U_W'(up_factor);

		if (down_factor == '0)
			d_eff = D_W'(1);
		else if (32'(down_factor) > 32'(MAX_DOWN))
			d_eff = D_W'(MAX_DOWN);
		else
			d_eff = D_W'(down_factor);

		if (32'(tap_count) > 32'(MAX_COEFS))
			taps_eff = TP_W'(MAX_COEFS);
		else
			taps_eff = TP_W'(tap_count);
	end

	assign idx_ext = IX_W'(coef_index);
	assign idx_ok  = idx_ext < IX_W'(MAX_COEFS);

	assign head_nxt   = (head_q == HA_W'(HISTORY_DEPTH - 1)) ? '0 : head_q + HA_W'(1);
	assign phase_sum  = (PW+1)'(phase_q) + (PW+1)'(d_eff);
	assign phase_diff = phase_q - PW'(u_eff);

	// Status to controller
	assign sts.phase_lt_u = phase_q < PW'(u_eff);
	assign sts.next_lt_u  = phase_sum < (PW+1)'(u_eff);
	assign sts.tap_more   = (k_q < K_W'(taps_eff)) && (j_q < fill_q);
	assign sts.pipe_busy  = v_s1 | v_s2;
	assign sts.out_free   = !out_valid_q || out_ready;

	// Coefficient memory
	always_ff @(posedge clk) begin
		if (cmd.coef_wr && idx_ok)
			coef_mem[idx_ext[CA_W-1:0]] <= coef_value;
		if (cmd.mac_issue)
			coef_rd_s1 <= coef_mem[k_q[CA_W-1:0]];
	end

	// Sample history memory
	always_ff @(posedge clk) begin
		if (cmd.hist_push)
			hist_mem[head_nxt] <= sample;
		if (cmd.mac_issue)
			hist_rd_s1 <= hist_mem[rptr_q];
	end

	// History pointer, fill count and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			fill_q  <= '0;
			phase_q <= '0;
		end else begin
			if (cmd.hist_push) begin
				head_q <= head_nxt;
				if (fill_q != FL_W'(HISTORY_DEPTH))
					fill_q <= fill_q + FL_W'(1);
			end
			if (cmd.phase_adv)
				phase_q <= phase_sum[PW-1:0];
			else if (cmd.phase_end)
				phase_q <= PW'(phase_diff[PHASE_W-1:0]);
		end
	end

	// Tap walk: k steps by U, history pointer steps back one sample
	always_ff @(posedge clk) begin
		if (cmd.out_start) begin
			k_q    <= K_W'(phase_q);
			j_q    <= '0;
			rptr_q <= head_q;
		end else if (cmd.mac_issue) begin
			k_q    <= k_q + K_W'(u_eff);
			j_q    <= j_q + FL_W'(1);
			rptr_q <= (rptr_q == '0) ? HA_W'(HISTORY_DEPTH - 1) : rptr_q - HA_W'(1);
		end
	end

	// MAC pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.mac_issue;
			v_s2 <= v_s1;
		end
	end

	// Multiply and accumulate
	always_ff @(posedge clk) begin
		prod_s2 <= coef_rd_s1 * hist_rd_s1;
		if (cmd.out_start)
			acc_q <= '0;
		else if (v_s2)
			acc_q <= acc_q + ACC_W'(prod_s2);
	end

	// Round half up, then saturate to the sample range
	always_comb begin
		rnd_v   = (ACC_W+1)'(acc_q) + (ACC_W+1)'(ROUND_HALF);
		rnd_q   = rnd_v[ACC_W:FRAC_W];
		rnd_top = rnd_q[Q_W-1:SMP_W-1];
		if ((&rnd_top) || !(|rnd_top))
			rnd_res = rnd_q[SMP_W-1:0];
		else if (rnd_q[Q_W-1])
			rnd_res = SAT_MIN;
		else
			rnd_res = SAT_MAX;
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_sample_q <= rnd_res;
			out_last_q   <= cmd.out_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign out_last   = out_last_q;

	// Accumulator must have settled when a result is taken from it
	a_acc_settled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(v_s1 || v_s2))
		else $error("result taken while MAC pipeline busy");

	// Stored phase wraps into PHASE_W bits at the end of each sample
	a_phase_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.phase_end |=> !phase_q[PW-1])
		else $error("stored phase out of range");

	// Fill count never passes the history depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FL_W'(HISTORY_DEPTH))
		else $error("history fill count overflow");

endmodule

[rtl/core/polyphase_rational_resampler_core.sv]
// Polyphase rational resampler core: one coefficient or sample word in, resampled words out.
// Coefficient word: taken with no result. Sample word: per output due, about
// min(ceil((taps-phase)/U), samples held) MAC steps, bound by the single read port of
// the tap memory; up to U outputs per sample, next word taken once the last result is queued.
// Reset (arst_n, asynchronous): U = D = tap count = 1, phase and history pointer zero, history
// fill count zero so the history reads as zeros; tap memory is not cleared, no clearing pass.
module polyphase_rational_resampler_core import rpr_pkg::*; #(
	parameter int MAX_COEFS     = 4096,
	parameter int MAX_UP        = 32,
	parameter int MAX_DOWN      = 64,
	parameter int HISTORY_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	rpr_in_if.sink            items,
	rpr_out_if.source         results
);

	logic [UP_W-1:0]   up_factor;
	logic [DOWN_W-1:0] down_factor;
	logic [TAPS_W-1:0] tap_count;
	rpr_cmd_t          cmd;
	rpr_sts_t          sts;

	rpr_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.up_factor   (up_factor),
		.down_factor (down_factor),
		.tap_count   (tap_count)
	);

	rpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_opcode (items.opcode),
		.in_ready  (items.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rpr_datapath #(
		.MAX_COEFS     (MAX_COEFS),
		.MAX_UP        (MAX_UP),
		.MAX_DOWN      (MAX_DOWN),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.up_factor   (up_factor),
		.down_factor (down_factor),
		.tap_count   (tap_count),
		.coef_index  (items.coef_index),
		.coef_value  (items.coef_value),
		.sample      (items.sample),
		.out_ready   (results.ready),
		.out_valid   (results.valid),
		.out_sample  (results.out_sample),
		.out_last    (results.last)
	);

endmodule

[verif/testbench.sv]
// Self-checking testbench of the polyphase resampler core: APB set-up, directed and random word streams.
module testbench;
	import rpr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_TAPS      = 4096;
	localparam int UP_LIM        = 32;
	localparam int DOWN_LIM      = 64;
	localparam int HIST_LEN      = 256;
	localparam int SETTLE_CYCLES = 300;
	localparam int STALL_LIMIT   = 20000;
	localparam int REPORT_CAP    = 100;

	typedef struct {
		logic                    opcode;
		logic [CI_W-1:0]         coef_index;
		logic signed [CV_W-1:0]  coef_value;
		logic signed [SMP_W-1:0] sample;
		bit                      hold;
	} in_word_t;

	typedef struct {
		logic signed [SMP_W-1:0] out_sample;
		logic                    last;
	} out_word_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	rpr_in_if  in_words();
	rpr_out_if out_words();

	polyphase_rational_resampler_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.items   (in_words),
		.results (out_words)
	);

	// Stimulus and expected output words
	in_word_t  stim_words[$];
	out_word_t due_outputs[$];
	bit        tap_loaded[MAX_TAPS];

	// Shadow of the filter state and registers
	int                tap_mem[MAX_TAPS];
	int                hist_mem[HIST_LEN];
	logic [7:0]        hist_head = '0;
	logic [PHASE_W-1:0] out_phase = '0;
	logic [UP_W-1:0]   up_reg   = UP_RST;
	logic [DOWN_W-1:0] down_reg = DOWN_RST;
	logic [TAPS_W-1:0] taps_reg = TAPS_RST;

	int send_idle = 26;
	int take_idle = 61;
	int fault_count = 0;
	int words_taken = 0;
	int samples_taken = 0;
	int outputs_checked = 0;
	int settings_run = 0;
	int stall_cycles = 0;

	// Clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Push one sample into the shadow history and queue every output word due
	function automatic void compute_outputs(input logic signed [SMP_W-1:0] smp);
		int u, d, taps, ph, k, j, n;
		longint acc, q;
		logic [7:0] pos;
		out_word_t w;
		hist_head = hist_head + 8'd1;
		hist_mem[hist_head] = smp;
		u = int'(up_reg);
		if (u < 1) u = 1;
		if (u > UP_LIM) u = UP_LIM;
		d = int'(down_reg);
		if (d < 1) d = 1;
		if (d > DOWN_LIM) d = DOWN_LIM;
		taps = int'(taps_reg);
		if (taps > MAX_TAPS) taps = MAX_TAPS;
		ph = int'(out_phase);
		n = 0;
		while (ph < u) begin
			acc = 0;
			k = ph;
			j = 0;
			// taps older than the history depth drop out
			while (k < taps && j < HIST_LEN) begin
				pos = hist_head - 8'(j);
				acc += longint'(tap_mem[k]) * longint'(hist_mem[pos]);
				k += u;
				j++;
			end
			// round half up to Q1.15, then saturate
			q = (acc + 64'sd16384) >>> FRAC_W;
			if (q > 32767) q = 32767;
			if (q < -32768) q = -32768;
			w.out_sample = SMP_W'(q);
			w.last = 1'b0;
			due_outputs = {due_outputs, w};
			n++;
			ph += d;
		end
		if (n > 0) due_outputs[due_outputs.size() - 1].last = 1'b1;
		out_phase = PHASE_W'(ph - u);
	endfunction

	// Random signed value, half the time of reduced magnitude
	function automatic int rand_signed(input int full);
		int w, r;
		w = ($urandom_range(1) == 1) ? full : int'($urandom_range(full - 1, 2));
		r = int'($urandom);
		return (r <<< (32 - w)) >>> (32 - w);
	endfunction

	function automatic void queue_word(input logic op, input int idx, input int cval,
			input int smp, input bit hold);
		in_word_t w;
		w.opcode     = op;
		w.coef_index = CI_W'(idx);
		w.coef_value = CV_W'(cval);
		w.sample     = SMP_W'(smp);
		w.hold       = hold;
		if (op == OP_COEF) tap_loaded[idx] = 1'b1;
		stim_words = {stim_words, w};
	endfunction

	// Input driver
	always @(posedge clk) begin : drive_words
		bit took, send;
		took = in_words.valid && in_words.ready;
		if (took) void'(stim_words.pop_front());
		if (!arst_n) begin
			send = 1'b0;
		end else if (in_words.valid && !took) begin
			send = 1'b1;
		end else begin
			send = stim_words.size() != 0 && $urandom_range(99) >= send_idle;
			// a held word waits until every due output word has come back
			if (send && stim_words[0].hold && (took || due_outputs.size() != 0))
				send = 1'b0;
		end
		in_words.valid <= send;
		if (send) begin
			in_words.opcode     <= stim_words[0].opcode;
			in_words.coef_index <= stim_words[0].coef_index;
			in_words.coef_value <= stim_words[0].coef_value;
			in_words.sample     <= stim_words[0].sample;
		end
	end

	// Output back-pressure
	always @(posedge clk) begin : take_words
		if (!arst_n) begin
			out_words.ready <= 1'b0;
		end else begin
			out_words.ready <= $urandom_range(99) >= take_idle;
		end
	end

	// Monitor: check output words first, then predict from the accepted input word
	always @(posedge clk) begin : check_words
		out_word_t want;
		if (arst_n) begin
			if (out_words.valid && out_words.ready) begin
				if (due_outputs.size() == 0) begin
					fault_count++;
					if (fault_count <= REPORT_CAP)
						$display("%0t unexpected output word: expected none, got %0d last %0b",
							$time, out_words.out_sample, out_words.last);
				end else begin
					want = due_outputs.pop_front();
					outputs_checked++;
					if (out_words.out_sample !== want.out_sample) begin
						fault_count++;
						if (fault_count <= REPORT_CAP)
							$display("%0t out_sample mismatch: expected %0d, got %0d",
								$time, want.out_sample, out_words.out_sample);
					end
					if (out_words.last !== want.last) begin
						fault_count++;
						if (fault_count <= REPORT_CAP)
							$display("%0t last mismatch: expected %0b, got %0b",
								$time, want.last, out_words.last);
					end
				end
			end
			if (in_words.valid && in_words.ready) begin
				words_taken++;
				if (in_words.opcode == OP_COEF) begin
					tap_mem[in_words.coef_index] = int'(in_words.coef_value);
				end else begin
					samples_taken++;
					compute_outputs(in_words.sample);
				end
			end
		end
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_words.valid && in_words.ready) ||
				(out_words.valid && out_words.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("[polyphase_rational_resampler_core] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// APB write followed by a read-back of the same register
	task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] got, mask;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_UP: begin
				up_reg = value[UP_W-1:0];
				mask = APB_DW'((1 << UP_W) - 1);
			end
			REG_DOWN: begin
				down_reg = value[DOWN_W-1:0];
				mask = APB_DW'((1 << DOWN_W) - 1);
			end
			default: begin
				taps_reg = value[TAPS_W-1:0];
				mask = APB_DW'((1 << TAPS_W) - 1);
			end
		endcase
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		got = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if ((got & mask) !== (value & mask)) begin
			fault_count++;
			$display("%0t register %0d read-back mismatch: expected %0d, got %0d",
				$time, idx, value & mask, got & mask);
		end
	endtask

	// Wait until every word is in and every output word has come, then let the core settle
	task automatic wait_drained();
		@(negedge clk);
		while (stim_words.size() != 0 || due_outputs.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register setting: write, load any taps it reads, then a stream of words
	task automatic run_phase(input int up_v, input int down_v, input int taps_v,
			input int n_words, input int regime, input bit samples_only);
		int u, t, need, k, i, idx;
		wait_drained();
		write_reg(REG_UP, APB_DW'(up_v));
		write_reg(REG_DOWN, APB_DW'(down_v));
		write_reg(REG_TAPS, APB_DW'(taps_v));
		settings_run++;
		case (regime)
			0: begin
				send_idle = 26;
				take_idle = 61;
			end
			1: begin
				send_idle = 61;
				take_idle = 26;
			end
			default: begin
				send_idle = 0;
				take_idle = 0;
			end
		endcase
		@(negedge clk);
		u = (up_v < 1) ? 1 : ((up_v > UP_LIM) ? UP_LIM : up_v);
		t = (taps_v > MAX_TAPS) ? MAX_TAPS : taps_v;
		need = (t < u * HIST_LEN) ? t : u * HIST_LEN;
		// every tap the filter can read must hold a value first
		for (k = 0; k < need; k++)
			if (!tap_loaded[k])
				queue_word(OP_COEF, k, rand_signed(CV_W), int'($urandom), 1'b0);
		for (i = 0; i < n_words; i++) begin
			if (!samples_only && $urandom_range(3) == 0) begin
				if ($urandom_range(1) == 1 || need == 0)
					idx = int'($urandom_range(MAX_TAPS - 1));
				else
					idx = int'($urandom_range(need - 1));
				queue_word(OP_COEF, idx, rand_signed(CV_W), int'($urandom), i == n_words / 2);
			end else begin
				queue_word(OP_SAMPLE, int'($urandom_range(MAX_TAPS - 1)), int'($urandom),
					rand_signed(SMP_W), i == n_words / 2);
			end
		end
	endtask

	initial begin
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		in_words.valid      = 1'b0;
		in_words.opcode     = OP_COEF;
		in_words.coef_index = '0;
		in_words.coef_value = '0;
		in_words.sample     = '0;
		out_words.ready     = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words at the reset setting (one tap, U = D = 1)
		queue_word(OP_COEF, 0, 131071, 0, 1'b0);
		queue_word(OP_COEF, MAX_TAPS - 1, -131072, -1, 1'b0);
		queue_word(OP_SAMPLE, 0, 0, 32767, 1'b0);
		queue_word(OP_SAMPLE, 0, 0, -32768, 1'b0);
		queue_word(OP_COEF, 0, -131072, 0, 1'b0);
		queue_word(OP_SAMPLE, 0, 0, -32768, 1'b0);
		queue_word(OP_SAMPLE, 0, 0, 32767, 1'b0);
		// half-LSB products: rounding goes up
		queue_word(OP_COEF, 0, 16384, 0, 1'b0);
		queue_word(OP_SAMPLE, 0, 0, 1, 1'b0);
		queue_word(OP_SAMPLE, 0, 0, -1, 1'b0);
		queue_word(OP_SAMPLE, 0, 0, 3, 1'b0);
		queue_word(OP_SAMPLE, 0, 0, -3, 1'b0);
		queue_word(OP_COEF, 0, 32768, 0, 1'b0);
		queue_word(OP_SAMPLE, 0, 0, -12345, 1'b0);
		queue_word(OP_SAMPLE, 0, 0, 0, 1'b0);

		// zero factors clamp to one, zero taps give silence
		run_phase(0, 0, 0, 3, 0, 1'b1);
		// oversized U clamps to the maximum: most output words per sample
		run_phase(63, 1, 64, 3, 0, 1'b1);
		// oversized D: phase runs past U, samples with no output due
		run_phase(2, 127, 8, 4, 0, 1'b1);

		// Random streams over a spread of settings
		run_phase(3, 2, 30, 15, 0, 1'b0);
		run_phase(2, 3, 24, 15, 0, 1'b0);
		run_phase(4, 1, 48, 12, 0, 1'b0);
		run_phase(1, 3, 16, 15, 1, 1'b0);
		run_phase(32, 2, 64, 10, 1, 1'b0);
		run_phase(int'($urandom_range(8, 1)), int'($urandom_range(12, 1)),
			int'($urandom_range(80, 1)), 15, 1, 1'b0);
		run_phase(5, 4, 40, 15, 2, 1'b0);
		// tap count above the maximum: history depth bounds the sum
		run_phase(1, 1, 8191, 12, 2, 1'b0);
		run_phase(int'($urandom_range(8, 1)), int'($urandom_range(12, 1)),
			int'($urandom_range(80, 1)), 15, 2, 1'b0);

		wait_drained();
		$display("Covered %0d input words (%0d samples) over %0d register settings;",
			words_taken, samples_taken, settings_run);
		$display("%0d resampled output words checked, %0d faults.", outputs_checked,
			fault_count);
		if (fault_count == 0) begin
			$display("[polyphase_rational_resampler_core] OK");
		end else begin
			$display("[polyphase_rational_resampler_core] ERROR");
		end
		$finish;
	end

endmodule
